### sv/rgb_led_mode_color_generator_core_defines.svh
// ----------------------------------------------------------------------------
// RGB LED mode color generator: assertion macros
// Shared concurrent assertion forms for the color generator core.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_MODE_COLOR_GENERATOR_CORE_DEFINES_SVH
`define RGB_LED_MODE_COLOR_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RLMCG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RLMCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rlmcg_pkg.sv
// ----------------------------------------------------------------------------
// RGB LED mode color generator package
// Request and result types, mode codes and color wheel constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rlmcg_pkg;

  // Mode codes of a request. All other codes behave as off.
  localparam logic [2:0] ModeOn      = 3'd0;
  localparam logic [2:0] ModeOff     = 3'd1;
  localparam logic [2:0] ModeRainbow = 3'd2;
  localparam logic [2:0] ModeBlink   = 3'd3;

  localparam logic [8:0]  HueWrap      = 9'd360;
  localparam logic [8:0]  SectorSpan   = 9'd60;
  localparam logic [7:0]  Full         = 8'hFF;
  localparam logic [15:0] BlinkResetMs = 16'd1000;

  typedef struct packed {
    logic [2:0]  mode_code;
    logic [7:0]  user_red;
    logic [7:0]  user_green;
    logic [7:0]  user_blue;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

endpackage

`default_nettype wire

### sv/rgb_led_mode_color_generator_core.sv
// Result: an accepted request's result is registered into the output
// register, or into the skid register when the head is stalled.
// Throughput: one request per cycle while in_stall is low; the single-pass
// mode logic and the two-entry output buffer set that.
// Reset: synchronous, active low; clears hue, blink phase and deadline, loads
// the blink period with 1000 ms and empties the output buffer.
// ----------------------------------------------------------------------------
// RGB LED mode color generator core
// Turns one update request (mode, user color, time) into one RGB result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_led_mode_color_generator_core_defines.svh"

module rgb_led_mode_color_generator_core
  import rlmcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel.
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire in_item_t    in_data,
  // Result channel.
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      out_item_t   out_data,
  // Blink period register write.
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [15:0] cfg_blink_period_ms
);

  // State carried from request to request.
  logic [8:0]  hue_count_r,      hue_count_nxt;
  logic        blink_phase_r,    blink_phase_nxt;
  logic [31:0] blink_deadline_r, blink_deadline_nxt;
  logic [15:0] period_r;

  // Output buffer: the head register drives the port, the skid register
  // catches a result that arrives while the head is stalled.
  logic        out_vld_r,  skid_vld_r;
  out_item_t   out_data_r, skid_data_r;

  logic        acc;
  logic        out_take;
  logic        blink_due;
  logic [9:0]  hue_inc;
  out_item_t   wheel_color;
  out_item_t   user_color;
  out_item_t   result;

  // The register port never pushes back; the user must write only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  // Stall is taken straight from a register: a request is refused only when
  // both buffer entries hold results.
  assign in_stall  = skid_vld_r;
  assign acc       = in_valid && !skid_vld_r;
  assign out_take  = out_vld_r && !out_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  assign user_color = '{out_red:   in_data.user_red,
                        out_green: in_data.user_green,
                        out_blue:  in_data.user_blue};

  // The hue advances first, and anything past 360 folds back to zero.
  assign hue_inc = {1'b0, hue_count_r} + 10'd1;

  // The deadline compare is unsigned, so time wrapping past 2^32 is not
  // treated specially.
  assign blink_due = in_data.now_ms >= blink_deadline_r;

  always_comb begin
    hue_count_nxt      = hue_count_r;
    blink_phase_nxt    = blink_phase_r;
    blink_deadline_nxt = blink_deadline_r;
    case (in_data.mode_code)
      ModeRainbow: begin
        hue_count_nxt = (hue_inc > {1'b0, HueWrap}) ? 9'd0 : hue_inc[8:0];
      end
      ModeBlink: begin
        if (blink_due) begin
          blink_deadline_nxt = in_data.now_ms + {16'd0, period_r};
          blink_phase_nxt    = !blink_phase_r;
        end
      end
      default: begin
      end
    endcase
  end

  // The wheel sees the already advanced hue.
  rlmcg_wheel u_wheel (
    .hue   (hue_count_nxt),
    .color (wheel_color)
  );

  always_comb begin
    case (in_data.mode_code)
      ModeOn:      result = user_color;
      ModeRainbow: result = wheel_color;
      ModeBlink:   result = blink_phase_nxt ? '0 : user_color;
      default:     result = '0;
    endcase
  end

  // Mode state moves only on accepted requests.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_count_r      <= '0;
      blink_phase_r    <= 1'b0;
      blink_deadline_r <= '0;
      period_r         <= BlinkResetMs;
    end else begin
      if (acc) begin
        hue_count_r      <= hue_count_nxt;
        blink_phase_r    <= blink_phase_nxt;
        blink_deadline_r <= blink_deadline_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        period_r <= cfg_blink_period_ms;
      end
    end
  end

  // Output buffer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && !out_take) begin
        if (acc) begin
          skid_vld_r <= 1'b1;
        end
      end else if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= acc;
      end
    end
  end

  // Buffer payload, no reset needed.
  always_ff @(posedge clk) begin
    if (out_vld_r && !out_take) begin
      if (acc) begin
        skid_data_r <= result;
      end
    end else if (skid_vld_r) begin
      out_data_r <= skid_data_r;
    end else if (acc) begin
      out_data_r <= result;
    end
  end

  `RLMCG_ASSERT_SAME(a_hue_range, 1'b1, hue_count_r <= HueWrap, "hue count beyond 360")
  `RLMCG_ASSERT_SAME(a_skid_behind_head, skid_vld_r, out_vld_r, "skid entry without head")
  `RLMCG_ASSERT_NEXT(a_hue_hold, acc && (in_data.mode_code != ModeRainbow), $stable(hue_count_r), "hue moved outside rainbow mode")
  `RLMCG_ASSERT_NEXT(a_blink_toggle, acc && (in_data.mode_code == ModeBlink) && blink_due, blink_phase_r != $past(blink_phase_r), "blink phase missed its deadline")
  `RLMCG_ASSERT_NEXT(a_no_loss, out_vld_r && out_stall && acc, skid_vld_r && out_vld_r, "result dropped under stall")

endmodule

`default_nettype wire

### sv/rlmcg_wheel.sv
// ----------------------------------------------------------------------------
// RGB LED mode color generator: color wheel
// Maps a hue of 0..360 degrees to a fully saturated 8-bit RGB triple.
// ----------------------------------------------------------------------------
`default_nettype none

module rlmcg_wheel
  import rlmcg_pkg::*;
(
  input  wire logic [8:0] hue,
  output out_item_t       color
);

  localparam logic [2:0] Sec0 = 3'd0;
  localparam logic [2:0] Sec1 = 3'd1;
  localparam logic [2:0] Sec2 = 3'd2;
  localparam logic [2:0] Sec3 = 3'd3;
  localparam logic [2:0] Sec4 = 3'd4;

  logic [8:0] h;
  logic [8:0] base;
  logic [2:0] sector;
  logic [5:0] rem;
  logic [9:0] prod;
  logic [9:0] prod_up;
  logic [7:0] t;
  logic [7:0] q;

  // A hue of 360 lands on the same point as 0.
  assign h = (hue >= HueWrap) ? 9'd0 : hue;

  always_comb begin
    if (h < SectorSpan) begin
      sector = Sec0;
      base   = 9'd0;
    end else if (h < 9'(2 * SectorSpan)) begin
      sector = Sec1;
      base   = SectorSpan;
    end else if (h < 9'(3 * SectorSpan)) begin
      sector = Sec2;
      base   = 9'(2 * SectorSpan);
    end else if (h < 9'(4 * SectorSpan)) begin
      sector = Sec3;
      base   = 9'(3 * SectorSpan);
    end else if (h < 9'(5 * SectorSpan)) begin
      sector = Sec4;
      base   = 9'(4 * SectorSpan);
    end else begin
      sector = 3'd5;
      base   = 9'(5 * SectorSpan);
    end
  end

  // Within a sector the ramp is 17*rem/4: floor for rising, ceiling for falling.
  assign rem     = 6'(h - base);
  assign prod    = {rem, 4'b0000} + {4'b0000, rem};
  assign prod_up = prod + 10'd3;
  assign t       = prod[9:2];
  assign q       = Full - prod_up[9:2];

  always_comb begin
    case (sector)
      Sec0: color = '{out_red: Full,  out_green: t,     out_blue: 8'd0};
      Sec1: color = '{out_red: q,     out_green: Full,  out_blue: 8'd0};
      Sec2: color = '{out_red: 8'd0,  out_green: Full,  out_blue: t};
      Sec3: color = '{out_red: 8'd0,  out_green: q,     out_blue: Full};
      Sec4: color = '{out_red: t,     out_green: 8'd0,  out_blue: Full};
      default: color = '{out_red: Full, out_green: 8'd0, out_blue: q};
    endcase
  end

endmodule

`default_nettype wire
